// ===== rtl/core/bitmap_block_allocator_macros.svh =====
// assertion macros shared by the allocator checker
// no dependencies
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// clocked property, ignored while reset is high
`define BBA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds across reset
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bba_pkg.sv =====
// types, codes and helper functions for the bitmap block allocator
// no dependencies
`default_nettype none
package bba_pkg;

   localparam int WORD_W            = 32;
   localparam int WORDS_PER_SECTION = 128;
   localparam int SECTION_LIMIT     = 16;
   localparam int WIDX_W            = $clog2(WORDS_PER_SECTION);
   localparam int SEC_W             = $clog2(SECTION_LIMIT);
   localparam int SCNT_W            = $clog2(SECTION_LIMIT + 1);
   localparam int BIT_W             = $clog2(WORD_W);
   localparam int ADDR_W            = SEC_W + WIDX_W;
   localparam int TOTAL_WORDS       = WORDS_PER_SECTION * SECTION_LIMIT;
   localparam int BPS               = WORD_W * WORDS_PER_SECTION;
   localparam int USED_W            = 13;
   localparam logic [USED_W-1:0] USED_MAX = '1;
   localparam int LEN_W             = 6;
   localparam int IDX_W             = 16;
   localparam int RB_W              = 12;

   localparam logic [1:0] MODE_ALLOC  = 2'd0;
   localparam logic [1:0] MODE_FREE   = 2'd1;
   localparam logic [1:0] MODE_FORMAT = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [1:0] STATUS_BAD     = 2'd2;

   typedef struct packed {
      logic [1:0]       mode;
      logic [IDX_W-1:0] block_index;
      logic [LEN_W-1:0] run_length;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] granted_block;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_OPEN, ST_FMT_CHK, ST_FMT_WR, ST_FREE_WR, ST_SEC, ST_SCAN
   } state_type;

   typedef enum logic [2:0] {PH_PRE, PH_HINT, PH_DOWN, PH_UP, PH_NEW} phase_type;

   function automatic logic [WORD_W-1:0] run_mask(input logic [LEN_W-1:0] len,
                                                  input logic [BIT_W-1:0] bitpos);
      logic [WORD_W-1:0] m;
      if (len >= LEN_W'(WORD_W)) m = '1;
      else                       m = (WORD_W'(1) << len) - WORD_W'(1);
      return m << bitpos;
   endfunction

   function automatic logic [USED_W-1:0] sat_add(input logic [USED_W-1:0] a,
                                                 input logic [LEN_W-1:0] n);
      logic [USED_W:0] s;
      s = {1'b0, a} + (USED_W+1)'(n);
      return (s > (USED_W+1)'(USED_MAX)) ? USED_MAX : s[USED_W-1:0];
   endfunction

   function automatic logic [USED_W-1:0] sat_sub(input logic [USED_W-1:0] a,
                                                 input logic [LEN_W-1:0] n);
      return (a > USED_W'(n)) ? a - USED_W'(n) : '0;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bba_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/bitmap_block_allocator.sv =====
// bitmap block allocator top level: control sequencer around the bitmap ram
// depends on bba_pkg and bba_ram
//
// channel   ports                              direction
// request   start, busy, req_payload           in  (taken when start and !busy)
// response  rsp_valid, rsp_payload             out (one-cycle strobe)
// config    csr_write_enable, csr_write_data   in  (written at once)
//
// an allocate scans bitmap words and visits sections in search order; each
// section opened has every word cleared first. format clears the sections and
// does a read-modify-write of each reserved word. free does a read then a
// write; rejected requests answer the cycle after they are taken.
// no clearing pass after reset: a section's words are cleared when it opens.
// the receiver cannot stall, so busy only reflects the sequencer.
`default_nettype none
module bitmap_block_allocator (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire bba_pkg::req_type          req_payload,
   output logic                           rsp_valid,
   output bba_pkg::rsp_type               rsp_payload,
   input  wire logic                      csr_write_enable,
   input  wire logic [bba_pkg::RB_W-1:0]  csr_write_data
);
   import bba_pkg::*;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [1:0]         mode_ff, mode_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [SCNT_W-1:0]  hs_ff, hs_in;
   logic [WIDX_W-1:0]  hw_ff, hw_in;
   logic               hint_nz_ff, hint_nz_in;
   logic               back_ff, back_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [SCNT_W-1:0]  cur_s_ff, cur_s_in;
   logic [WIDX_W-1:0]  cur_w_ff, cur_w_in;
   logic [WIDX_W-1:0]  clr_ff, clr_in;
   logic [SCNT_W-1:0]  open_ff, open_in;
   logic [RB_W-1:0]    rb_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [USED_W-1:0]  used_ff [SECTION_LIMIT];

   logic               used_we, used_clr;
   logic [USED_W-1:0]  used_wdata, used_rd;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [WORD_W-1:0]  mem_wdata, mem_rdata;

   // request fields split
   logic [SCNT_W-1:0]  req_sec;
   logic [WIDX_W-1:0]  req_word;
   logic [BIT_W-1:0]   req_bit;
   logic               len_bad;

   // word scan
   logic [BIT_W:0]     top_pos;
   logic               fit;

   // section advance
   state_type          adv_state;
   phase_type          adv_phase;
   logic [SCNT_W-1:0]  adv_s;
   logic               adv_nospace;

   logic               fmt_last;
   logic [LEN_W-1:0]   fmt_cnt;
   logic [WORD_W-1:0]  fmt_mask;

   bba_ram #(.WIDTH(WORD_W), .DEPTH(TOTAL_WORDS)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign req_sec  = SCNT_W'(req_payload.block_index >> (BIT_W + WIDX_W));
   assign req_word = req_payload.block_index[BIT_W +: WIDX_W];
   assign req_bit  = req_payload.block_index[BIT_W-1:0];
   assign len_bad  = (req_payload.run_length == '0) ||
                     (req_payload.run_length > LEN_W'(WORD_W));
   assign used_rd  = used_ff[cur_s_ff[SEC_W-1:0]];

   // position just above the highest set bit
   always_comb begin
      top_pos = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (mem_rdata[i]) top_pos = (BIT_W+1)'(i + 1);
      end
   end
   assign fit = ((LEN_W+1)'(top_pos) + (LEN_W+1)'(len_ff)) <= (LEN_W+1)'(WORD_W);

   assign fmt_last = {cur_s_ff, cur_w_ff} == (SCNT_W+WIDX_W)'(rb_ff >> BIT_W);
   assign fmt_cnt  = fmt_last ? LEN_W'(rb_ff[BIT_W-1:0]) + LEN_W'(1) : LEN_W'(WORD_W);
   assign fmt_mask = run_mask(fmt_cnt, '0);

   // next section in search order after the current one gives up
   always_comb begin
      adv_state   = ST_SEC;
      adv_phase   = phase_ff;
      adv_s       = cur_s_ff;
      adv_nospace = 1'b0;
      case (phase_ff)
         PH_HINT: begin
            if (hs_ff != '0) begin
               adv_phase = PH_DOWN;
               adv_s     = hs_ff - SCNT_W'(1);
            end else begin
               adv_phase = PH_UP;
               adv_s     = hs_ff + SCNT_W'(1);
            end
         end
         PH_DOWN: begin
            if (cur_s_ff != '0) begin
               adv_s = cur_s_ff - SCNT_W'(1);
            end else begin
               adv_phase = PH_UP;
               adv_s     = hs_ff + SCNT_W'(1);
            end
         end
         PH_UP: adv_s = cur_s_ff + SCNT_W'(1);
         default: adv_nospace = 1'b1;
      endcase
      if (!adv_nospace && adv_phase == PH_UP && adv_s >= open_ff) begin
         // later sections exhausted: open a fresh one
         if (open_ff >= SCNT_W'(SECTION_LIMIT)) begin
            adv_nospace = 1'b1;
         end else begin
            adv_phase = PH_NEW;
            adv_s     = open_ff;
            adv_state = ST_OPEN;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      mode_in      = mode_ff;
      len_in       = len_ff;
      hs_in        = hs_ff;
      hw_in        = hw_ff;
      hint_nz_in   = hint_nz_ff;
      back_in      = back_ff;
      bit_in       = bit_ff;
      cur_s_in     = cur_s_ff;
      cur_w_in     = cur_w_ff;
      clr_in       = clr_ff;
      open_in      = open_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      used_we      = 1'b0;
      used_clr     = 1'b0;
      used_wdata   = used_rd;
      mem_we       = 1'b0;
      mem_waddr    = {cur_s_ff[SEC_W-1:0], cur_w_ff};
      mem_wdata    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in    = req_payload.mode;
               len_in     = req_payload.run_length;
               hs_in      = req_sec;
               hw_in      = req_word;
               bit_in     = req_bit;
               hint_nz_in = req_payload.block_index[BIT_W+WIDX_W-1:0] != '0;
               back_in    = 1'b0;
               clr_in     = '0;
               rsp_in     = '{status: STATUS_BAD, granted_block: '0};
               case (req_payload.mode)
                  MODE_ALLOC: begin
                     if (len_bad) begin
                        rsp_valid_in = 1'b1;
                     end else if (req_sec >= SCNT_W'(SECTION_LIMIT)) begin
                        rsp_in.status = STATUS_NOSPACE;
                        rsp_valid_in  = 1'b1;
                     end else if (open_ff <= req_sec) begin
                        phase_in = PH_PRE;
                        cur_s_in = open_ff;
                        state_in = ST_OPEN;
                     end else begin
                        phase_in = PH_HINT;
                        cur_s_in = req_sec;
                        cur_w_in = req_word;
                        state_in = ST_SEC;
                     end
                  end
                  MODE_FREE: begin
                     if (len_bad || ((LEN_W+1)'(req_bit) +
                                     (LEN_W+1)'(req_payload.run_length)) >
                                    (LEN_W+1)'(WORD_W) ||
                         req_sec >= open_ff) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        cur_s_in = req_sec;
                        cur_w_in = req_word;
                        state_in = ST_FREE_WR;
                     end
                  end
                  MODE_FORMAT: begin
                     used_clr = 1'b1;
                     open_in  = '0;
                     cur_s_in = '0;
                     cur_w_in = '0;
                     state_in = ST_FMT_CHK;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end

         ST_OPEN: begin
            mem_we    = 1'b1;
            mem_waddr = {cur_s_ff[SEC_W-1:0], clr_ff};
            // the section's own bitmap block is bit 0 of its last word
            mem_wdata = (clr_ff == WIDX_W'(WORDS_PER_SECTION - 1)) ? WORD_W'(1) : '0;
            clr_in    = clr_ff + WIDX_W'(1);
            if (clr_ff == WIDX_W'(WORDS_PER_SECTION - 1)) begin
               clr_in     = '0;
               used_we    = 1'b1;
               used_wdata = USED_W'(1);
               open_in    = open_ff + SCNT_W'(1);
               if (mode_ff == MODE_FORMAT) begin
                  state_in = ST_FMT_CHK;
               end else if (phase_ff == PH_PRE) begin
                  if (open_ff + SCNT_W'(1) <= hs_ff) begin
                     cur_s_in = open_ff + SCNT_W'(1);
                  end else begin
                     phase_in = PH_HINT;
                     cur_s_in = hs_ff;
                     cur_w_in = hw_ff;
                     state_in = ST_SEC;
                  end
               end else begin
                  cur_w_in = '0;
                  back_in  = 1'b0;
                  state_in = ST_SEC;
               end
            end
         end

         ST_FMT_CHK: begin
            if (cur_s_ff >= SCNT_W'(SECTION_LIMIT)) begin
               rsp_in       = '{status: STATUS_OK, granted_block: '0};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (cur_s_ff >= open_ff) begin
               clr_in   = '0;
               state_in = ST_OPEN;
            end else begin
               state_in = ST_FMT_WR;
            end
         end

         ST_FMT_WR: begin
            mem_we     = 1'b1;
            mem_wdata  = mem_rdata | fmt_mask;
            used_we    = 1'b1;
            used_wdata = sat_add(used_rd, fmt_cnt);
            if (fmt_last) begin
               rsp_in       = '{status: STATUS_OK, granted_block: '0};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               {cur_s_in, cur_w_in} = {cur_s_ff, cur_w_ff} + (SCNT_W+WIDX_W)'(1);
               state_in             = ST_FMT_CHK;
            end
         end

         ST_FREE_WR: begin
            mem_we       = 1'b1;
            mem_wdata    = mem_rdata & ~run_mask(len_ff, bit_ff);
            used_we      = 1'b1;
            used_wdata   = sat_sub(used_rd, len_ff);
            rsp_in       = '{status: STATUS_OK, granted_block: '0};
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_SEC: begin
            // skip a section that cannot hold the run
            if (({1'b0, used_rd} + (USED_W+1)'(len_ff)) > (USED_W+1)'(BPS)) begin
               if (adv_nospace) begin
                  rsp_in       = '{status: STATUS_NOSPACE, granted_block: '0};
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  phase_in = adv_phase;
                  cur_s_in = adv_s;
                  cur_w_in = '0;
                  back_in  = 1'b0;
                  clr_in   = '0;
                  state_in = adv_state;
               end
            end else begin
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (fit) begin
               mem_we       = 1'b1;
               mem_wdata    = mem_rdata | run_mask(len_ff, top_pos[BIT_W-1:0]);
               used_we      = 1'b1;
               used_wdata   = sat_add(used_rd, len_ff);
               rsp_in       = '{status: STATUS_OK,
                                granted_block: IDX_W'({cur_s_ff[SEC_W-1:0], cur_w_ff,
                                                       top_pos[BIT_W-1:0]})};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (!back_ff && cur_w_ff != WIDX_W'(WORDS_PER_SECTION - 1)) begin
               cur_w_in = cur_w_ff + WIDX_W'(1);
            end else if (!back_ff && phase_ff == PH_HINT && hint_nz_ff) begin
               // forward pass ended: sweep back down from the hint word
               back_in  = 1'b1;
               cur_w_in = hw_ff;
            end else if (back_ff && cur_w_ff != '0) begin
               cur_w_in = cur_w_ff - WIDX_W'(1);
            end else if (adv_nospace) begin
               rsp_in       = '{status: STATUS_NOSPACE, granted_block: '0};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               phase_in = adv_phase;
               cur_s_in = adv_s;
               cur_w_in = '0;
               back_in  = 1'b0;
               clr_in   = '0;
               state_in = adv_state;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // read address comes from the next-state values, so the registered word is ready in the state that uses it
   assign mem_raddr = {cur_s_in[SEC_W-1:0], cur_w_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= '0;
         rb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         for (int i = 0; i < SECTION_LIMIT; i++) used_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         if (csr_write_enable) begin
            rb_ff <= csr_write_data;
         end
         if (used_clr) begin
            for (int i = 0; i < SECTION_LIMIT; i++) used_ff[i] <= '0;
         end else if (used_we) begin
            used_ff[cur_s_ff[SEC_W-1:0]] <= used_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      phase_ff   <= phase_in;
      mode_ff    <= mode_in;
      len_ff     <= len_in;
      hs_ff      <= hs_in;
      hw_ff      <= hw_in;
      hint_nz_ff <= hint_nz_in;
      back_ff    <= back_in;
      bit_ff     <= bit_in;
      cur_s_ff   <= cur_s_in;
      cur_w_ff   <= cur_w_in;
      rsp_ff     <= rsp_in;
   end

   assign busy        = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule
`default_nettype wire

// ===== rtl/core/bba_checker.sv =====
// port-level checks for the bitmap block allocator, bound to the top level
// depends on bba_pkg and bitmap_block_allocator_macros.svh
`default_nettype none
`include "bitmap_block_allocator_macros.svh"
module bba_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire bba_pkg::rsp_type rsp_payload
);
   import bba_pkg::*;

   // every accepted transaction either answers at once or goes busy
   `BBA_ASSERT(a_take, clock, reset, start && !busy |=> rsp_valid || busy, "transaction lost")
   // a response comes out only with the sequencer free again
   `BBA_ASSERT(a_done, clock, reset, rsp_valid |-> !busy, "response while busy")
   `BBA_ASSERT(a_fell, clock, reset, $fell(busy) |-> rsp_valid, "busy ended without response")
   `BBA_ASSERT(a_grant, clock, reset, rsp_valid && rsp_payload.status != STATUS_OK |-> rsp_payload.granted_block == '0, "grant on failure")
   `BBA_ASSERT_ALWAYS(a_rst, clock, reset |=> !rsp_valid && !busy, "activity after reset")
endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
`default_nettype wire
